>>> src/wsr_pkg.sv
// shared types, codes and pulse mapping for the window servo ramp controller
// no dependencies
package wsr_pkg;

  localparam int THR_W = 12;
  localparam logic [THR_W-1:0] THR_RESET = 12'd2000;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_MODE  = 2'd1;
  localparam logic [1:0] CMD_GAP   = 2'd2;
  localparam logic [1:0] CMD_STALL = 2'd3;

  localparam logic [1:0] MODE_CLOSED  = 2'd0;
  localparam logic [1:0] MODE_OPEN    = 2'd1;
  localparam logic [1:0] MODE_VENT    = 2'd2;
  localparam logic [1:0] MODE_INVALID = 2'd3;

  localparam logic [7:0] ANG_CLOSED = 8'd0;
  localparam logic [7:0] ANG_OPEN   = 8'd90;
  localparam logic [7:0] ANG_VENT   = 8'd180;

  localparam logic [6:0] GAP_MAX = 7'd100;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_BAD_MODE = 3'd1;
  localparam logic [2:0] ST_NOT_OPEN = 3'd2;
  localparam logic [2:0] ST_BUSY     = 3'd3;
  localparam logic [2:0] ST_STEPPED  = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;
  localparam logic [2:0] ST_ABORT    = 3'd6;
  localparam logic [2:0] ST_IDLE     = 3'd7;

  typedef struct packed {
    logic [1:0] command;
    logic [1:0] mode_request;
    logic [7:0] gap_request;
    logic       simulate_on;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] handle_pulse_us;
    logic [11:0] gap_pulse_us;
    logic [1:0]  window_mode_now;
    logic [6:0]  gap_percent_now;
    logic        stall_flag;
    logic        busy_res;
  } result_t;

  // 500 + 2000*a/180 = 500 + floor(100*a/9), reciprocal 7282/2^16 is exact for a < 256
  function automatic logic [11:0] pulse_of(logic [7:0] angle);
    logic [14:0] x;
    logic [27:0] p;
    x = 15'(angle) * 15'd100;
    p = 28'(x) * 28'd7282;
    return 12'd500 + p[27:16];
  endfunction

  // floor(pct*90/100) = floor(9*pct/10), reciprocal 205/2^11 is exact for pct <= 100
  function automatic logic [7:0] gap_goal_of(logic [6:0] pct);
    logic [9:0]  x;
    logic [17:0] p;
    x = 10'(pct) * 10'd9;
    p = 18'(x) * 18'd205;
    return {1'b0, p[17:11]};
  endfunction

endpackage

>>> src/wsr_core.sv
// servo move state and per-item update logic
// depends on wsr_pkg
module wsr_core import wsr_pkg::*; #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  item_t                  item,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   cfg_we,
  input  logic [THR_W-1:0]       cfg_wdata,
  output result_t                res
);

  localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HANDLE = 2'd1,
    PH_GAP    = 2'd2,
    PH_CHAIN  = 2'd3
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [THR_W-1:0] thr_r;
  logic [7:0]       handle_r, handle_nxt;
  logic [7:0]       gap_r, gap_nxt;
  logic [7:0]       next_r, next_nxt;
  logic [7:0]       goal_r, goal_nxt;
  logic [1:0]       pmode_r, pmode_nxt;
  logic [6:0]       pgap_r, pgap_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic [6:0]       pct_r, pct_nxt;
  logic             latch_r, latch_nxt;
  logic [2:0]       status;
  logic [6:0]       pct_req;
  logic [7:0]       mode_goal;
  logic             over;

  assign pct_req = (item.gap_request > 8'(GAP_MAX)) ? GAP_MAX : item.gap_request[6:0];
  assign over    = CMP_W'(sample) > CMP_W'(thr_r);

  always_comb begin
    case (item.mode_request)
      MODE_OPEN: mode_goal = ANG_OPEN;
      MODE_VENT: mode_goal = ANG_VENT;
      default:   mode_goal = ANG_CLOSED;
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    handle_nxt = handle_r;
    gap_nxt    = gap_r;
    next_nxt   = next_r;
    goal_nxt   = goal_r;
    pmode_nxt  = pmode_r;
    pgap_nxt   = pgap_r;
    mode_nxt   = mode_r;
    pct_nxt    = pct_r;
    latch_nxt  = latch_r;
    status     = ST_ACCEPTED;
    unique case (item.command)
      CMD_TICK: begin
        if (phase_r == PH_IDLE) begin
          status = ST_IDLE;
        end else begin
          if (phase_r == PH_HANDLE) begin
            handle_nxt = next_r;
          end else begin
            gap_nxt = next_r;
          end
          if (latch_r || over) begin
            latch_nxt = 1'b1;
            phase_nxt = PH_IDLE;
            status    = ST_ABORT;
          end else if (next_r == goal_r) begin
            status    = ST_DONE;
            phase_nxt = PH_IDLE;
            if (phase_r == PH_HANDLE) begin
              mode_nxt = pmode_r;
              if (pmode_r == MODE_CLOSED) begin
                pct_nxt = '0;
                // chained gap move back to zero
                if (gap_r != 8'd0) begin
                  phase_nxt = PH_CHAIN;
                  next_nxt  = gap_r;
                  goal_nxt  = 8'd0;
                end
              end
            end else if (phase_r == PH_GAP) begin
              pct_nxt = pgap_r;
            end
          end else begin
            next_nxt = (next_r < goal_r) ? next_r + 8'd1 : next_r - 8'd1;
            status   = ST_STEPPED;
          end
        end
      end
      CMD_MODE: begin
        if (phase_r != PH_IDLE) begin
          status = ST_BUSY;
        end else if (item.mode_request == MODE_INVALID) begin
          status = ST_BAD_MODE;
        end else begin
          pmode_nxt = item.mode_request;
          goal_nxt  = mode_goal;
          if (handle_r == mode_goal) begin
            mode_nxt = item.mode_request;
            if (item.mode_request == MODE_CLOSED) begin
              pct_nxt = '0;
              if (gap_r != 8'd0) begin
                phase_nxt = PH_CHAIN;
                next_nxt  = gap_r;
                goal_nxt  = 8'd0;
              end
            end
          end else begin
            phase_nxt = PH_HANDLE;
            next_nxt  = handle_r;
          end
        end
      end
      CMD_GAP: begin
        if (phase_r != PH_IDLE) begin
          status = ST_BUSY;
        end else if (mode_r != MODE_OPEN) begin
          status = ST_NOT_OPEN;
        end else begin
          pgap_nxt = pct_req;
          goal_nxt = gap_goal_of(pct_req);
          if (gap_r == gap_goal_of(pct_req)) begin
            pct_nxt = pct_req;
          end else begin
            phase_nxt = PH_GAP;
            next_nxt  = gap_r;
          end
        end
      end
      default: begin
        latch_nxt = item.simulate_on;
      end
    endcase
  end

  always_comb begin
    res.status          = status;
    res.handle_pulse_us = pulse_of(handle_nxt);
    res.gap_pulse_us    = pulse_of(gap_nxt);
    res.window_mode_now = mode_nxt;
    res.gap_percent_now = pct_nxt;
    res.stall_flag      = latch_nxt;
    res.busy_res        = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      thr_r    <= THR_RESET;
      handle_r <= '0;
      gap_r    <= '0;
      next_r   <= '0;
      goal_r   <= '0;
      pmode_r  <= MODE_CLOSED;
      pgap_r   <= '0;
      mode_r   <= MODE_CLOSED;
      pct_r    <= '0;
      latch_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (step_en) begin
        phase_r  <= phase_nxt;
        handle_r <= handle_nxt;
        gap_r    <= gap_nxt;
        next_r   <= next_nxt;
        goal_r   <= goal_nxt;
        pmode_r  <= pmode_nxt;
        pgap_r   <= pgap_nxt;
        mode_r   <= mode_nxt;
        pct_r    <= pct_nxt;
        latch_r  <= latch_nxt;
      end
    end
  end

endmodule

>>> src/window_servo_ramp_controller.sv
// top level: input register, update core and result register
// depends on wsr_pkg and wsr_core
//
//   channel  ports                                    direction  handshake
//   in       in_command .. in_simulate_on             to block   in_valid / in_stall
//   out      out_status .. out_busy_res               from block out_valid / out_stall
//   cfg      cfg_wr_en, cfg_wr_data (stall_threshold) to block   write enable, no wait
//
// one beat per cycle sustained while out_stall stays low; a taken beat waits in the input register,
// then the single-pass update writes its result into the result register
// rst_n is synchronous: it empties both registers, sets the threshold to 2000 and homes state
// out_stall holds the result register; the input register keeps taking a beat while
// the result register drains, and in_stall rises only when both are full and stalled
module window_servo_ramp_controller import wsr_pkg::*; #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_command,
  input  logic [1:0]             in_mode_request,
  input  logic [7:0]             in_gap_request,
  input  logic [SAMPLE_BITS-1:0] in_current_sample,
  input  logic                   in_simulate_on,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             out_status,
  output logic [11:0]            out_handle_pulse_us,
  output logic [11:0]            out_gap_pulse_us,
  output logic [1:0]             out_window_mode_now,
  output logic [6:0]             out_gap_percent_now,
  output logic                   out_stall_flag,
  output logic                   out_busy_res,
  input  logic                   cfg_wr_en,
  input  logic [THR_W-1:0]       cfg_wr_data
);

  logic                   in_v_r;
  item_t                  item_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic                   out_v_r;
  result_t                res_r;
  result_t                res_nxt;
  logic                   step_en;
  logic                   in_take;

  assign step_en  = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !step_en;
  assign in_take  = in_valid && !in_stall;

  wsr_core #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (step_en),
    .item     (item_r),
    .sample   (sample_r),
    .cfg_we   (cfg_wr_en),
    .cfg_wdata(cfg_wr_data),
    .res      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_v_r <= 1'b1;
      end else if (step_en) begin
        in_v_r <= 1'b0;
      end
      if (step_en) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.command      <= in_command;
      item_r.mode_request <= in_mode_request;
      item_r.gap_request  <= in_gap_request;
      item_r.simulate_on  <= in_simulate_on;
      sample_r            <= in_current_sample;
    end
    if (step_en) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_v_r;
  assign out_status          = res_r.status;
  assign out_handle_pulse_us = res_r.handle_pulse_us;
  assign out_gap_pulse_us    = res_r.gap_pulse_us;
  assign out_window_mode_now = res_r.window_mode_now;
  assign out_gap_percent_now = res_r.gap_percent_now;
  assign out_stall_flag      = res_r.stall_flag;
  assign out_busy_res        = res_r.busy_res;

endmodule

>>> test/testbench.sv
// self-checking testbench for window_servo_ramp_controller: directed beats, then random
// servo moves under several stall thresholds, checked against a cycle-free servo predictor
// depends on wsr_pkg and window_servo_ramp_controller
module testbench;
  import wsr_pkg::*;

  localparam int SAMPLE_W = 12;
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int THR_MAX = (1 << THR_W) - 1;
  localparam int PHASE_BEATS = 250;
  localparam int PHASES = 5;

  typedef enum logic [1:0] {MV_IDLE, MV_HANDLE, MV_GAP, MV_CHAIN} move_t;

  class servo_tracker;
    logic [THR_W-1:0] threshold;
    logic [7:0] handle_ang;
    logic [7:0] gap_ang;
    logic [7:0] step_ang;
    logic [7:0] goal_ang;
    move_t phase;
    logic [1:0] pend_mode;
    logic [1:0] mode;
    logic [6:0] pend_gap;
    logic [6:0] gap_pct;
    logic latch;
    result_t due_reports[$];
    int errors;
    int moves_done;
    int aborts;

    function new();
      threshold = THR_RESET;
      handle_ang = '0;
      gap_ang = '0;
      step_ang = '0;
      goal_ang = '0;
      phase = MV_IDLE;
      pend_mode = MODE_CLOSED;
      mode = MODE_CLOSED;
      pend_gap = '0;
      gap_pct = '0;
      latch = 1'b0;
      errors = 0;
      moves_done = 0;
      aborts = 0;
    endfunction

    function logic [11:0] pulse_width(logic [7:0] ang);
      return 12'(500 + (2000 * int'(ang)) / 180);
    endfunction

    function void finish_move(move_t ph);
      phase = MV_IDLE;
      if (ph == MV_HANDLE) begin
        mode = pend_mode;
        if (pend_mode == MODE_CLOSED) begin
          gap_pct = '0;
          // closing pulls the gap servo home as well
          if (gap_ang != 8'd0) begin
            phase = MV_CHAIN;
            step_ang = gap_ang;
            goal_ang = 8'd0;
          end
        end
      end else if (ph == MV_GAP) begin
        gap_pct = pend_gap;
      end
    endfunction

    function result_t step_servos(logic [1:0] cmd, logic [1:0] mreq, logic [7:0] greq,
                                  logic [SAMPLE_W-1:0] sample, logic sim);
      result_t r;
      logic [6:0] pct;
      r.status = ST_ACCEPTED;
      case (cmd)
        CMD_TICK: begin
          if (phase == MV_IDLE) begin
            r.status = ST_IDLE;
          end else begin
            if (phase == MV_HANDLE) handle_ang = step_ang;
            else gap_ang = step_ang;
            if (latch || sample > threshold) begin
              latch = 1'b1;
              phase = MV_IDLE;
              r.status = ST_ABORT;
              aborts++;
            end else if (step_ang == goal_ang) begin
              finish_move(phase);
              r.status = ST_DONE;
              moves_done++;
            end else begin
              step_ang = (step_ang < goal_ang) ? step_ang + 8'd1 : step_ang - 8'd1;
              r.status = ST_STEPPED;
            end
          end
        end
        CMD_MODE: begin
          if (phase != MV_IDLE) begin
            r.status = ST_BUSY;
          end else if (mreq == MODE_INVALID) begin
            r.status = ST_BAD_MODE;
          end else begin
            pend_mode = mreq;
            case (mreq)
              MODE_OPEN: goal_ang = ANG_OPEN;
              MODE_VENT: goal_ang = ANG_VENT;
              default:   goal_ang = ANG_CLOSED;
            endcase
            if (handle_ang == goal_ang) begin
              finish_move(MV_HANDLE);
            end else begin
              phase = MV_HANDLE;
              step_ang = handle_ang;
            end
          end
        end
        CMD_GAP: begin
          if (phase != MV_IDLE) begin
            r.status = ST_BUSY;
          end else if (mode != MODE_OPEN) begin
            r.status = ST_NOT_OPEN;
          end else begin
            pct = (greq > 8'(GAP_MAX)) ? GAP_MAX : greq[6:0];
            pend_gap = pct;
            goal_ang = 8'((int'(pct) * 90) / 100);
            if (gap_ang == goal_ang) begin
              finish_move(MV_GAP);
            end else begin
              phase = MV_GAP;
              step_ang = gap_ang;
            end
          end
        end
        default: latch = sim;
      endcase
      r.handle_pulse_us = pulse_width(handle_ang);
      r.gap_pulse_us = pulse_width(gap_ang);
      r.window_mode_now = mode;
      r.gap_percent_now = gap_pct;
      r.stall_flag = latch;
      r.busy_res = (phase != MV_IDLE);
      return r;
    endfunction

    function void note_beat(logic [1:0] cmd, logic [1:0] mreq, logic [7:0] greq,
                            logic [SAMPLE_W-1:0] sample, logic sim);
      due_reports.push_back(step_servos(cmd, mreq, greq, sample, sim));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_report(result_t got);
      result_t want;
      if (due_reports.size() == 0) begin
        $display("%0t: result beat with none expected, status %0d", $time, got.status);
        errors++;
        return;
      end
      want = due_reports.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("handle_pulse_us", 32'(want.handle_pulse_us), 32'(got.handle_pulse_us));
      compare_field("gap_pulse_us", 32'(want.gap_pulse_us), 32'(got.gap_pulse_us));
      compare_field("window_mode_now", 32'(want.window_mode_now), 32'(got.window_mode_now));
      compare_field("gap_percent_now", 32'(want.gap_percent_now), 32'(got.gap_percent_now));
      compare_field("stall_flag", 32'(want.stall_flag), 32'(got.stall_flag));
      compare_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [1:0] in_command = CMD_TICK;
  logic [1:0] in_mode_request = MODE_CLOSED;
  logic [7:0] in_gap_request = '0;
  logic [SAMPLE_W-1:0] in_current_sample = '0;
  logic in_simulate_on = 1'b0;
  logic out_stall = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [THR_W-1:0] cfg_wr_data = THR_RESET;

  logic in_stall;
  logic out_valid;
  logic [2:0] out_status;
  logic [11:0] out_handle_pulse_us;
  logic [11:0] out_gap_pulse_us;
  logic [1:0] out_window_mode_now;
  logic [6:0] out_gap_percent_now;
  logic out_stall_flag;
  logic out_busy_res;

  servo_tracker tracker;
  bit calm = 1'b0;
  int stall_left = 0;
  int beats = 0;

  window_servo_ramp_controller #(.SAMPLE_BITS(SAMPLE_W)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_command(in_command),
    .in_mode_request(in_mode_request),
    .in_gap_request(in_gap_request),
    .in_current_sample(in_current_sample),
    .in_simulate_on(in_simulate_on),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_handle_pulse_us(out_handle_pulse_us),
    .out_gap_pulse_us(out_gap_pulse_us),
    .out_window_mode_now(out_window_mode_now),
    .out_gap_percent_now(out_gap_percent_now),
    .out_stall_flag(out_stall_flag),
    .out_busy_res(out_busy_res),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("FAIL window_servo_ramp_controller");
    $finish;
  end

  // receiver stalls in short bursts
  always @(posedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_report({out_status, out_handle_pulse_us, out_gap_pulse_us,
                            out_window_mode_now, out_gap_percent_now, out_stall_flag,
                            out_busy_res});
  end

  task automatic send_beat(input logic [1:0] cmd, input logic [1:0] mreq,
                           input logic [7:0] greq, input logic [SAMPLE_W-1:0] sample,
                           input logic sim);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_mode_request <= mreq;
    in_gap_request <= greq;
    in_current_sample <= sample;
    in_simulate_on <= sim;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.note_beat(cmd, mreq, greq, sample, sim);
    beats++;
  endtask

  task automatic send_mode(input logic [1:0] m);
    send_beat(CMD_MODE, m, 8'($urandom), SAMPLE_W'($urandom), 1'($urandom));
  endtask

  task automatic send_gap(input logic [7:0] g);
    send_beat(CMD_GAP, 2'($urandom), g, SAMPLE_W'($urandom), 1'($urandom));
  endtask

  task automatic send_latch(input logic s);
    send_beat(CMD_STALL, 2'($urandom), 8'($urandom), SAMPLE_W'($urandom), s);
  endtask

  task automatic send_tick(input logic hot);
    logic [SAMPLE_W-1:0] s;
    if (hot && int'(tracker.threshold) < SAMPLE_MAX)
      s = SAMPLE_W'($urandom_range(int'(tracker.threshold) + 1, SAMPLE_MAX));
    else
      s = SAMPLE_W'($urandom_range(0, int'(tracker.threshold)));
    send_beat(CMD_TICK, 2'($urandom), 8'($urandom), s, 1'($urandom));
  endtask

  function automatic logic [1:0] pick_mode();
    if ($urandom_range(0, 19) == 0) return MODE_INVALID;
    return 2'($urandom_range(0, 2));
  endfunction

  function automatic logic [7:0] pick_gap();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(101, 255));
    return 8'($urandom_range(0, 100));
  endfunction

  // ticks until the predicted move ends, with the odd busy request or stall in between
  task automatic run_move();
    int r;
    while (tracker.phase != MV_IDLE) begin
      r = $urandom_range(0, 199);
      if (r < 3) send_mode(2'($urandom));
      else if (r < 6) send_gap(8'($urandom));
      else if (r < 7) send_latch(1'($urandom));
      else if (r < 9) send_tick(1'b1);
      else send_tick(1'b0);
    end
  endtask

  task automatic run_scenario();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      send_mode(pick_mode());
    end else if (pick < 75) begin
      if (tracker.mode != MODE_OPEN && $urandom_range(0, 3) != 0) begin
        send_mode(MODE_OPEN);
        run_move();
      end
      send_gap(pick_gap());
    end else if (pick < 85) begin
      send_latch(1'($urandom));
    end else begin
      send_beat(2'($urandom), 2'($urandom), 8'($urandom), SAMPLE_W'($urandom),
                1'($urandom));
    end
    run_move();
    if (tracker.latch && $urandom_range(0, 4) != 0) send_latch(1'b0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.due_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] v);
    wait_drained();
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.threshold = v;
  endtask

  initial begin
    int start;
    logic [THR_W-1:0] thr;
    tracker = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle ticks, rejects, zero-length move, latch aborts, busy, threshold edge
    send_beat(CMD_TICK, MODE_CLOSED, 8'd0, '0, 1'b0);
    send_beat(CMD_TICK, MODE_INVALID, 8'hff, SAMPLE_W'(SAMPLE_MAX), 1'b1);
    send_mode(MODE_INVALID);
    send_gap(8'hff);
    send_mode(MODE_CLOSED);
    send_gap(8'd0);
    send_latch(1'b1);
    send_mode(MODE_OPEN);
    send_beat(CMD_TICK, MODE_CLOSED, 8'd0, '0, 1'b0);
    send_latch(1'b0);
    send_mode(MODE_OPEN);
    send_mode(MODE_VENT);
    send_gap(8'd50);
    send_mode(MODE_INVALID);
    send_latch(1'b0);
    send_beat(CMD_TICK, MODE_CLOSED, 8'd0, SAMPLE_W'(THR_RESET), 1'b0);
    send_beat(CMD_TICK, MODE_CLOSED, 8'd0, SAMPLE_W'(THR_RESET - 1), 1'b0);
    send_beat(CMD_TICK, MODE_CLOSED, 8'd0, SAMPLE_W'(THR_RESET + 1), 1'b0);
    send_beat(CMD_TICK, MODE_CLOSED, 8'd0, '0, 1'b0);
    send_latch(1'b0);
    send_mode(MODE_CLOSED);
    repeat (3) send_beat(CMD_TICK, MODE_CLOSED, 8'd0, '0, 1'b0);
    send_mode(MODE_CLOSED);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: thr = THR_W'(THR_MAX);
        1: thr = '0;
        PHASES - 1: thr = THR_W'(1);
        default: thr = THR_W'($urandom_range(2, THR_MAX - 1));
      endcase
      write_threshold(thr);
      calm = (p == PHASES - 1);
      start = beats;
      while (beats - start < PHASE_BEATS) run_scenario();
    end

    wait_drained();
    repeat (6) @(posedge clk);
    $display("%0d beats over %0d stall thresholds, both extremes included", beats, PHASES + 1);
    $display("%0d servo moves finished, %0d stopped by a stall", tracker.moves_done,
             tracker.aborts);
    if (tracker.errors == 0) begin
      $display("PASS window_servo_ramp_controller");
    end else begin
      $display("FAIL window_servo_ramp_controller");
    end
    $finish;
  end

endmodule
